@@ rtl/core/glr_pkg.sv @@
`default_nettype none

package glr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int OPERAND_W      = 32;
    localparam int RESULT_W       = 32;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_NEG = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    // input request: one list element
    typedef struct packed {
        logic                        opcode;
        logic signed [OPERAND_W-1:0] operand;
        logic                        last_element;
    } t_req;

    typedef struct packed {
        logic [RESULT_W-1:0] reduced_value;
        t_status             status;
    } t_rsp;

    // shared arithmetic unit operations
    typedef enum logic {
        AU_GCD = 1'b0,
        AU_DIV = 1'b1
    } t_au_op;

    typedef struct packed {
        logic   start;
        t_au_op op;
    } t_au_ctl;

endpackage

`default_nettype wire

@@ rtl/core/glr_stream_if.sv @@
`default_nettype none

interface glr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gcd_lcm_list_reducer_core.sv @@
// gcd / lcm list reducer
//
// i_req (sink) takes one list element per request: opcode (0 gcd, 1 lcm),
// a signed 32-bit operand and last_element. o_rsp (source) gives one
// result request per list, on the element marked last: the reduced value
// and a status (ok, negative element seen, lcm or operand overflow).
// The block takes one element at a time; i_req.ready is high only while
// the sequencer is idle. A seeding, negative, zero-in-lcm or out-of-range
// element is handled in the idle state. A gcd element runs the binary gcd
// in the shared unit on W-bit values, W = min(VALUE_BITS, 32): one
// compare/subtract or shift per cycle. An lcm element runs the gcd, then
// the quotient acc / gcd by restoring division, then a multiply and a
// compare. The last element then passes the emit step, which loads the
// output register. The output register holds the result until
// o_rsp.ready; the next list may start meanwhile, and the block waits only
// if a second result is due before the first one is taken.
// Reset (synchronous, active low) rearms the list: the next element seeds
// the accumulator, all flags are cleared and no result is pending.
`default_nettype none

module gcd_lcm_list_reducer_core #(
    parameter int VALUE_BITS = glr_pkg::VALUE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    glr_stream_if.sink       i_req,
    glr_stream_if.source     o_rsp
);

    localparam int ACC_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int PROD_W = 2 * ACC_W;
    localparam logic [31:0] LIM =
        (ACC_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ACC_W) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_LGCD,
        S_DIV,
        S_MUL,
        S_CHK,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_v;
    logic [PROD_W-1:0]   r_prod;
    logic                r_first;
    logic                r_neg;
    logic                r_zero;
    logic                r_ovf;
    logic                r_last;
    logic                r_out_valid;
    glr_pkg::t_rsp       r_out;

    logic                w_accept;
    logic                w_neg;
    logic                w_big;
    logic                w_lcm;
    logic [31:0]         w_v32;
    logic [ACC_W-1:0]    w_v;
    t_state              w_end;
    t_state              w_fin;
    logic                w_load;

    glr_pkg::t_au_ctl    au_ctl;
    logic [ACC_W-1:0]    au_a;
    logic [ACC_W-1:0]    au_b;
    logic                au_done;
    logic [ACC_W-1:0]    au_result;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_neg = i_req.data.operand[31];
    assign w_v32 = {1'b0, i_req.data.operand[30:0]};
    assign w_big = w_v32 > LIM;
    assign w_v   = w_v32[ACC_W-1:0];
    assign w_lcm = i_req.data.opcode;
    assign w_end = i_req.data.last_element ? S_EMIT : S_IDLE;
    assign w_fin = r_last ? S_EMIT : S_IDLE;
    // output register free or being emptied this cycle
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        au_ctl.start = 1'b0;
        au_ctl.op    = glr_pkg::AU_GCD;
        au_a         = r_acc;
        au_b         = w_v;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !w_neg && !w_big && !r_first &&
                    (!w_lcm || (w_v != '0 && !r_zero && r_acc != '0))) begin
                    au_ctl.start = 1'b1;
                end
            end
            S_LGCD: begin
                // quotient acc / gcd follows the gcd directly
                if (au_done) begin
                    au_ctl.start = 1'b1;
                    au_ctl.op    = glr_pkg::AU_DIV;
                    au_b         = au_result;
                end
            end
            default: ;
        endcase
    end

    glr_arith_unit #(
        .W (ACC_W)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (au_ctl),
        .i_a      (au_a),
        .i_b      (au_b),
        .o_done   (au_done),
        .o_result (au_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_first     <= 1'b1;
            r_neg       <= 1'b0;
            r_zero      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_v    <= w_v;
                        r_last <= i_req.data.last_element;
                        if (w_neg) begin
                            r_neg   <= 1'b1;
                            r_first <= 1'b0;
                            r_state <= w_end;
                        end else if (w_big) begin
                            r_ovf   <= 1'b1;
                            r_first <= 1'b0;
                            r_state <= w_end;
                        end else begin
                            if (w_lcm && w_v == '0) begin
                                r_zero <= 1'b1;
                            end
                            if (r_first) begin
                                r_acc   <= w_v;
                                r_first <= 1'b0;
                                r_state <= w_end;
                            end else if (!w_lcm) begin
                                r_state <= S_GCD;
                            end else if (w_v == '0 || r_zero || r_acc == '0) begin
                                r_state <= w_end;
                            end else begin
                                r_state <= S_LGCD;
                            end
                        end
                    end
                end
                S_GCD: begin
                    if (au_done) begin
                        r_acc   <= au_result;
                        r_state <= w_fin;
                    end
                end
                S_LGCD: begin
                    if (au_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (au_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(au_result) * PROD_W'(r_v);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // lcm above the limit is flagged, accumulator kept
                    if (r_prod > PROD_W'(LIM)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_acc <= r_prod[ACC_W-1:0];
                    end
                    r_state <= w_fin;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out.reduced_value <= (r_neg || r_zero || r_ovf) ?
                                               '0 : glr_pkg::RESULT_W'(r_acc);
                        if (r_neg) begin
                            r_out.status <= glr_pkg::ST_NEG;
                        end else if (r_zero) begin
                            r_out.status <= glr_pkg::ST_OK;
                        end else if (r_ovf) begin
                            r_out.status <= glr_pkg::ST_OVF;
                        end else begin
                            r_out.status <= glr_pkg::ST_OK;
                        end
                        // rearm for the next list
                        r_acc   <= '0;
                        r_first <= 1'b1;
                        r_neg   <= 1'b0;
                        r_zero  <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // a new result only comes out of the emit step
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside emit step");

    // the shared unit finishes only while the sequencer waits for it
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        au_done |-> (r_state == S_GCD || r_state == S_LGCD || r_state == S_DIV))
        else $error("arith unit done while sequencer not waiting");

    // an error status always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.status == glr_pkg::ST_OK ||
                         o_rsp.data.reduced_value == '0))
        else $error("error status with nonzero value");

endmodule

`default_nettype wire

@@ rtl/core/glr_arith_unit.sv @@
`default_nettype none

// iterative unit: binary gcd (compare, subtract, shift) or restoring division
module glr_arith_unit #(
    parameter int W = glr_pkg::VALUE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire glr_pkg::t_au_ctl i_ctl,
    input  wire logic [W-1:0]    i_a,
    input  wire logic [W-1:0]    i_b,
    output logic                 o_done,
    output logic [W-1:0]         o_result
);

    localparam int KW = $clog2(W + 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_GCD,
        U_SHL,
        U_DIV
    } t_state;

    t_state        r_state;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_rem;
    logic [KW-1:0] r_k;
    logic          r_done;

    logic [W:0]    w_rem_sh;
    logic [W:0]    w_dif;
    logic          w_ge;
    logic          n_done;

    // one restoring division step
    assign w_rem_sh = {r_rem, r_a[W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_b};
    assign w_dif    = w_rem_sh - {1'b0, r_b};

    // done pulse: gcd with a zero operand, odd operands equal with no shift left,
    // or the last shift / division step
    assign n_done = (r_state == U_IDLE && i_ctl.start && i_ctl.op == glr_pkg::AU_GCD &&
                     (i_a == '0 || i_b == '0)) ||
                    (r_state == U_GCD && r_a[0] && r_b[0] && r_a == r_b && r_k == '0) ||
                    ((r_state == U_SHL || r_state == U_DIV) && r_k == KW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            case (r_state)
                U_IDLE: begin
                    if (i_ctl.start) begin
                        r_b   <= i_b;
                        r_rem <= '0;
                        if (i_ctl.op == glr_pkg::AU_DIV) begin
                            r_a     <= i_a;
                            r_k     <= KW'(W);
                            r_state <= U_DIV;
                        end else if (i_a == '0) begin
                            r_a <= i_b;
                            r_k <= '0;
                        end else if (i_b == '0) begin
                            r_a <= i_a;
                            r_k <= '0;
                        end else begin
                            r_a     <= i_a;
                            r_k     <= '0;
                            r_state <= U_GCD;
                        end
                    end
                end
                U_GCD: begin
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a == r_b) begin
                        if (r_k == '0) begin
                            r_state <= U_IDLE;
                        end else begin
                            r_state <= U_SHL;
                        end
                    end else if (r_a > r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                U_SHL: begin
                    // restore the common power of two
                    r_a <= r_a << 1;
                    r_k <= r_k - 1'b1;
                    if (r_k == KW'(1)) begin
                        r_state <= U_IDLE;
                    end
                end
                U_DIV: begin
                    r_rem <= w_ge ? w_dif[W-1:0] : w_rem_sh[W-1:0];
                    r_a   <= {r_a[W-2:0], w_ge};
                    r_k   <= r_k - 1'b1;
                    if (r_k == KW'(1)) begin
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_a;

endmodule

`default_nettype wire
